>>> rtl/core/mhpq_pkg.sv
// Package with the item types, status and action codes of the min-heap priority queue.
package mhpq_pkg;

    // Default number of heap slots.
    localparam int DEFAULT_CAPACITY = 64;

    // Action codes of an input item.
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_EXTRACT  = 2'd1;
    localparam logic [1:0] ACT_DECREASE = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One input item.
    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] item_value;
        logic signed [31:0] item_key;
        logic signed [31:0] old_key;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] out_value;
        logic signed [31:0] out_key;
        logic        [6:0]  entry_count;
    } t_out_item;

    // One heap slot.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] key;
    } t_entry;

endpackage

>>> rtl/core/min_heap_priority_queue_core.sv
// Bounded binary min-heap priority queue with a sequenced memory datapath.
// Insert climbs from the new last slot; extract moves the last entry to the root and sinks it;
// decrease-key scans the slots in order for the old key and climbs from the match, and
// reports not found with no match. The input is ready only while idle, so a new item is
// taken only after the last result reaches the output register; one result may wait there.
// Reset clears the entry count and the sequencer; slot memory is not cleared.
module min_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mhpq_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mhpq_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = CW + 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_EX_LD  = 4'd3;
    localparam logic [3:0] S_DN_RD  = 4'd4;
    localparam logic [3:0] S_DN_CMP = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    mhpq_pkg::t_entry     r_cur, n_cur;
    logic signed [31:0]   r_old, n_old;
    logic [CW-1:0]        r_scan, n_scan;
    logic                 r_chk, n_chk;
    logic [IW-1:0]        r_chk_idx, n_chk_idx;
    mhpq_pkg::t_out_item  r_res, n_res;
    mhpq_pkg::t_out_item  r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    mhpq_pkg::t_entry     r_mem [CAPACITY];
    mhpq_pkg::t_entry     r_rd_a, r_rd_b;

    logic                 w_en;
    logic [IW-1:0]        w_addr;
    mhpq_pkg::t_entry     w_data;
    logic [IW-1:0]        addr_a, addr_b;

    logic [CW-1:0]        count_m1;
    logic [IW-1:0]        parent_idx;
    logic [XW-1:0]        left_w, right_w;
    logic                 left_ok, right_ok;
    logic [31:0]          count32;

    assign count_m1   = r_count - CW'(1);
    assign parent_idx = (r_idx - IW'(1)) >> 1;
    assign left_w     = (XW'(r_idx) << 1) + XW'(1);
    assign right_w    = left_w + XW'(1);
    assign left_ok    = left_w < XW'(r_count);
    assign right_ok   = right_w < XW'(r_count);
    assign count32    = 32'(r_count);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        logic signed [31:0] best_key;
        logic [IW-1:0]      best_idx;
        logic               moved;
        mhpq_pkg::t_entry   best_ent;

        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_old       = r_old;
        n_scan      = r_scan;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_en        = 1'b0;
        w_addr      = r_idx;
        w_data      = r_cur;
        addr_a      = '0;
        addr_b      = '0;
        best_key    = r_cur.key;
        best_idx    = r_idx;
        best_ent    = r_cur;
        moved       = 1'b0;

        // The output register drains on a transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '{status: mhpq_pkg::ST_OK, out_value: '0, out_key: '0,
                              entry_count: '0};
                    n_state = S_DONE;
                    case (i_in_item.action)
                        mhpq_pkg::ACT_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res.status = mhpq_pkg::ST_FULL;
                            end else begin
                                n_idx   = r_count[IW-1:0];
                                n_count = r_count + CW'(1);
                                n_cur   = '{value: i_in_item.item_value,
                                            key: i_in_item.item_key};
                                n_state = S_UP_RD;
                            end
                        end
                        mhpq_pkg::ACT_EXTRACT: begin
                            if (r_count == '0) begin
                                n_res.status = mhpq_pkg::ST_EMPTY;
                            end else begin
                                addr_a  = '0;
                                addr_b  = count_m1[IW-1:0];
                                n_state = S_EX_LD;
                            end
                        end
                        mhpq_pkg::ACT_DECREASE: begin
                            if ($signed(i_in_item.item_key) < $signed(i_in_item.old_key)) begin
                                n_old     = i_in_item.old_key;
                                n_cur.key = i_in_item.item_key;
                                n_scan    = '0;
                                n_chk     = 1'b0;
                                n_state   = S_SCAN;
                            end else begin
                                n_res.status = mhpq_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Sift up: fetch the parent, or settle at the root.
            S_UP_RD: begin
                if (r_idx == '0) begin
                    w_en    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    addr_a  = parent_idx;
                    n_state = S_UP_CMP;
                end
            end

            // Sift up: move the parent down into the hole, or settle here.
            S_UP_CMP: begin
                w_en = 1'b1;
                if ($signed(r_cur.key) < $signed(r_rd_a.key)) begin
                    w_data  = r_rd_a;
                    n_idx   = parent_idx;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Extract: latch the root as the result and take the last entry.
            S_EX_LD: begin
                n_res.out_value = r_rd_a.value;
                n_res.out_key   = r_rd_a.key;
                n_count         = count_m1;
                n_cur           = r_rd_b;
                n_idx           = '0;
                n_state         = (count_m1 == '0) ? S_DONE : S_DN_RD;
            end

            // Sift down: fetch both children, or settle at a leaf.
            S_DN_RD: begin
                if (!left_ok) begin
                    w_en    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    addr_a  = left_w[IW-1:0];
                    addr_b  = right_w[IW-1:0];
                    n_state = S_DN_CMP;
                end
            end

            // Sift down: left child first, then right, strict less-than.
            S_DN_CMP: begin
                if (left_ok && ($signed(r_rd_a.key) < $signed(best_key))) begin
                    best_key = r_rd_a.key;
                    best_idx = left_w[IW-1:0];
                    best_ent = r_rd_a;
                    moved    = 1'b1;
                end
                if (right_ok && ($signed(r_rd_b.key) < $signed(best_key))) begin
                    best_idx = right_w[IW-1:0];
                    best_ent = r_rd_b;
                    moved    = 1'b1;
                end
                w_en = 1'b1;
                if (moved) begin
                    w_data  = best_ent;
                    n_idx   = best_idx;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Decrease-key search: one read issued and one compare per cycle.
            S_SCAN: begin
                if (r_chk && (r_rd_a.key == r_old)) begin
                    n_cur.value = r_rd_a.value;
                    n_idx       = r_chk_idx;
                    n_state     = S_UP_RD;
                end else if (r_scan < r_count) begin
                    addr_a    = r_scan[IW-1:0];
                    n_chk     = 1'b1;
                    n_chk_idx = r_scan[IW-1:0];
                    n_scan    = r_scan + CW'(1);
                end else begin
                    n_chk        = 1'b0;
                    n_res.status = mhpq_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.entry_count = count32[6:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers are reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_old     <= n_old;
        r_scan    <= n_scan;
        r_chk_idx <= n_chk_idx;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

>>> test/heap_tracker_pkg.sv
// Scoreboard class that mirrors the min-heap contents and checks each response transfer.
package heap_tracker_pkg;

    localparam int HEAP_SLOTS = mhpq_pkg::DEFAULT_CAPACITY;

    class heap_tracker;
        logic signed [31:0]  slot_value [HEAP_SLOTS];
        logic signed [31:0]  slot_key [HEAP_SLOTS];
        int unsigned         fill;
        mhpq_pkg::t_out_item due_responses [$];
        int unsigned         mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return due_responses.size();
        endfunction

        // A key currently held in the heap, or zero when empty, so that decrease requests can hit.
        function logic signed [31:0] any_key();
            if (fill == 0) begin
                return '0;
            end
            return slot_key[$urandom_range(0, fill - 1)];
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [31:0] tv;
            logic signed [31:0] tk;
            tv = slot_value[a];
            tk = slot_key[a];
            slot_value[a] = slot_value[b];
            slot_key[a] = slot_key[b];
            slot_value[b] = tv;
            slot_key[b] = tk;
        endfunction

        // Move an entry toward the root while its key is strictly below its parent's.
        function void climb(int unsigned idx);
            int unsigned parent;
            while (idx > 0) begin
                parent = (idx - 1) / 2;
                if (!(slot_key[idx] < slot_key[parent])) begin
                    break;
                end
                swap_slots(idx, parent);
                idx = parent;
            end
        endfunction

        // Move an entry down; the left child wins ties against the right one.
        function void sink(int unsigned idx);
            int unsigned lc;
            int unsigned rc;
            int unsigned pick;
            while (idx < fill) begin
                lc = 2 * idx + 1;
                rc = lc + 1;
                pick = idx;
                if (lc < fill && slot_key[lc] < slot_key[pick]) begin
                    pick = lc;
                end
                if (rc < fill && slot_key[rc] < slot_key[pick]) begin
                    pick = rc;
                end
                if (pick == idx) begin
                    break;
                end
                swap_slots(idx, pick);
                idx = pick;
            end
        endfunction

        // Apply one accepted request to the mirrored heap and queue its response.
        function void apply_request(mhpq_pkg::t_in_item req);
            mhpq_pkg::t_out_item res;
            logic signed [31:0]  new_key;
            logic signed [31:0]  old_key;
            bit                  hit;
            res = '0;
            res.status = mhpq_pkg::ST_OK;
            new_key = req.item_key;
            old_key = req.old_key;
            case (req.action)
                mhpq_pkg::ACT_INSERT: begin
                    if (fill >= HEAP_SLOTS) begin
                        res.status = mhpq_pkg::ST_FULL;
                    end else begin
                        slot_value[fill] = req.item_value;
                        slot_key[fill] = new_key;
                        fill++;
                        climb(fill - 1);
                    end
                end
                mhpq_pkg::ACT_EXTRACT: begin
                    if (fill == 0) begin
                        res.status = mhpq_pkg::ST_EMPTY;
                    end else begin
                        res.out_value = slot_value[0];
                        res.out_key = slot_key[0];
                        fill--;
                        slot_value[0] = slot_value[fill];
                        slot_key[0] = slot_key[fill];
                        sink(0);
                    end
                end
                mhpq_pkg::ACT_DECREASE: begin
                    hit = 1'b0;
                    if (new_key < old_key) begin
                        for (int unsigned i = 0; i < fill && !hit; i++) begin
                            if (slot_key[i] == old_key) begin
                                slot_key[i] = new_key;
                                climb(i);
                                hit = 1'b1;
                            end
                        end
                    end
                    if (!hit) begin
                        res.status = mhpq_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
            res.entry_count = 7'(fill);
            due_responses.push_back(res);
        endfunction

        // Compare one response transfer with the oldest queued response.
        function void check_response(mhpq_pkg::t_out_item got);
            mhpq_pkg::t_out_item want;
            if (due_responses.size() == 0) begin
                $error("response transfer arrived with none expected");
                mismatches++;
                return;
            end
            want = due_responses.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.out_value !== want.out_value) begin
                $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
                mismatches++;
            end
            if (got.out_key !== want.out_key) begin
                $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       got.entry_count);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> test/tb_top.sv
// Testbench for the min-heap priority queue: directed and random requests with random stalls.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

    localparam int RANDOM_ITEMS = 1570;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 120;

    // Phase kinds of the random part.
    localparam int PH_FILL  = 0;
    localparam int PH_MIXED = 1;
    localparam int PH_DRAIN = 2;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    mhpq_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    mhpq_pkg::t_out_item o_out_item;

    heap_tracker_pkg::heap_tracker tracker;
    bit          burst_mode = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned idle_cycles = 0;

    min_heap_priority_queue_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // Gap length: mostly none or short, a few long; none in burst stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Keys lean toward a narrow band so that ties and matches are frequent.
    function automatic logic signed [31:0] rand_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return $urandom_range(0, 32) - 16;
        end else if (r < 85) begin
            return $urandom;
        end else if (r < 90) begin
            return KEY_MIN;
        end else if (r < 95) begin
            return KEY_MAX;
        end else if (r < 98) begin
            return KEY_MIN + $urandom_range(0, 3);
        end
        return KEY_MAX - $urandom_range(0, 3);
    endfunction

    function automatic mhpq_pkg::t_in_item make_item(logic [1:0] act,
                                                     logic signed [31:0] val,
                                                     logic signed [31:0] key,
                                                     logic signed [31:0] old);
        mhpq_pkg::t_in_item it;
        it.action = act;
        it.item_value = val;
        it.item_key = key;
        it.old_key = old;
        return it;
    endfunction

    // Random request whose action mix depends on the phase kind.
    function automatic mhpq_pkg::t_in_item rand_item(int kind);
        int unsigned        r;
        int unsigned        ins_lim;
        int unsigned        ext_lim;
        logic [1:0]         act;
        logic signed [31:0] old;
        logic signed [31:0] key;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL: begin
                ins_lim = 70;
                ext_lim = 85;
            end
            PH_DRAIN: begin
                ins_lim = 15;
                ext_lim = 80;
            end
            default: begin
                ins_lim = 40;
                ext_lim = 72;
            end
        endcase
        if (r < ins_lim) begin
            act = mhpq_pkg::ACT_INSERT;
        end else if (r < ext_lim) begin
            act = mhpq_pkg::ACT_EXTRACT;
        end else if (r < 97) begin
            act = mhpq_pkg::ACT_DECREASE;
        end else begin
            act = ACT_UNUSED;
        end
        old = ($urandom_range(0, 99) < 65) ? tracker.any_key() : rand_key();
        r = $urandom_range(0, 99);
        if (act != mhpq_pkg::ACT_DECREASE) begin
            key = rand_key();
        end else if (r < 60) begin
            key = old - $urandom_range(1, 20);
        end else if (r < 85) begin
            key = rand_key();
        end else begin
            key = old + $urandom_range(0, 3);
        end
        return make_item(act, $urandom, key, old);
    endfunction

    // Offer one request and return at the edge where it transfers.
    task automatic send_item(mhpq_pkg::t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do begin
            @(negedge i_clk);
        end while (!o_in_ready);
        @(posedge i_clk);
    endtask

    // Stop offering until every queued response has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Transfers are decided on values that are stable from the falling edge on.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.apply_request(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_response(o_out_item);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Response side: random stalls, ready in burst stretches, one long hold-off on request.
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (burst_mode) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Request side: reset, directed requests, then random phases.
    initial begin
        mhpq_pkg::t_in_item it;
        int unsigned        sent;
        int unsigned        phase;
        int unsigned        len;
        int                 kind;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty heap, ignored code, extremes, ties, rejected and accepted decreases.
        send_item(make_item(mhpq_pkg::ACT_EXTRACT, 32'sd7, 32'sd7, 32'sd7));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd1, 32'sd0, 32'sd5));
        send_item(make_item(ACT_UNUSED, KEY_MAX, KEY_MIN, 32'sd9));
        send_item(make_item(mhpq_pkg::ACT_INSERT, KEY_MAX, KEY_MAX, KEY_MIN));
        send_item(make_item(mhpq_pkg::ACT_INSERT, KEY_MIN, KEY_MIN, KEY_MAX));
        send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd0, 32'sd0, 32'sd0));
        send_item(make_item(mhpq_pkg::ACT_INSERT, -32'sd1, -32'sd1, -32'sd1));
        send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd5, 32'sd7, 32'sd0));
        send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd6, 32'sd7, 32'sd0));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd0, 32'sd7, 32'sd7));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd0, 32'sd8, 32'sd7));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd0, 32'sd0, 32'sd123));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd0, -32'sd5, 32'sd7));
        send_item(make_item(mhpq_pkg::ACT_DECREASE, 32'sd0, KEY_MIN, KEY_MAX));
        send_item(make_item(ACT_UNUSED, -32'sd1, -32'sd1, -32'sd1));
        repeat (8) begin
            send_item(make_item(mhpq_pkg::ACT_EXTRACT, 32'sd0, 32'sd0, 32'sd0));
        end

        // Random phases: insert-heavy fill, mixed traffic, extract-heavy drain.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase % 4)
                0: kind = PH_FILL;
                2: kind = PH_DRAIN;
                default: kind = PH_MIXED;
            endcase
            burst_mode = (phase % 5 == 3);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            len = $urandom_range(60, 150);
            repeat (len) begin
                it = rand_item(kind);
                send_item(it);
                sent++;
            end
            if (phase % 3 == 2) begin
                wait_drained();
            end
            phase++;
        end
        burst_mode = 1'b0;
        i_in_valid <= 1'b0;

        // Let the last responses come out, then allow for any work still in flight.
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
